### hdl/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// Shared sizes, status codes and store write types for the trie symbol table.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int ALPHABET   = 96;
   localparam int ID_COUNT   = 1024;

   localparam int FIRST_CHAR = 32;
   localparam int CHAR_END   = FIRST_CHAR + ALPHABET;

   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 3;
   localparam int ID_W     = 10;
   localparam int SYM_W    = 11;

   localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
   localparam int NODE_AW    = $clog2(NODE_COUNT);
   localparam int LINK_AW    = $clog2(LINK_DEPTH);
   localparam int POS_W      = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
   localparam int IDS_W      = $clog2(ID_COUNT + 1);

   localparam logic [SYM_W-1:0] NO_SYMBOL = '1;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEFINED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IDS_FULL  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 3'd5;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef struct packed {
      logic               en;
      logic [LINK_AW-1:0] addr;
      logic [NODE_AW-1:0] data;
   } link_wr_type;

   typedef struct packed {
      logic               en;
      logic [NODE_AW-1:0] addr;
      logic [SYM_W-1:0]   data;
   } sym_wr_type;

endpackage

### hdl/tst_channels.sv
// ----------------------------------------------------------------------------
// tst_channels
// Valid/ready channels for name characters in and lookup results out.
// ----------------------------------------------------------------------------
interface tst_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [tst_pkg::CHAR_W-1:0] character;
   logic                       last_char;

   modport source (output valid, command, character, last_char, input ready);
   modport sink   (input valid, command, character, last_char, output ready);
endinterface

interface tst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tst_pkg::STATUS_W-1:0] status;
   logic [tst_pkg::ID_W-1:0]     symbol_id;

   modport source (output valid, status, symbol_id, input ready);
   modport sink   (input valid, status, symbol_id, output ready);
endinterface

### hdl/trie_symbol_table_top.sv
// ----------------------------------------------------------------------------
// trie_symbol_table_top
// Character trie symbol table: look up or insert names one character per item.
// ----------------------------------------------------------------------------
// After reset the block sweeps the link and symbol memories, one entry per
// cycle, through all NODE_COUNT*ALPHABET link entries (98304 at the default
// sizes) before it raises req ready. A character that is not last passes a link
// memory read, then a compare and optional link write; a bad character, or one
// whose name has already failed, is settled when it is accepted. The last
// character of a name adds a symbol memory read and a step to load the result
// register; the symbol read is skipped when the walk fails on it, and the walk
// too when it is bad or the name had already failed. The load waits while the
// previous result is still held on the rsp side. One result per name.
module trie_symbol_table_top (
   input  logic           clock,
   input  logic           reset,
   tst_req_if.sink        req_chan,
   tst_rsp_if.source      rsp_chan
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_SYM   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [tst_pkg::LINK_AW-1:0]    clr_ff, clr_in;
   logic                           cmd_ff, cmd_in;
   logic                           last_ff, last_in;
   logic [tst_pkg::LINK_AW-1:0]    slot_ff, slot_in;
   logic [tst_pkg::NODE_AW-1:0]    cur_ff, cur_in;
   logic [tst_pkg::NODE_AW:0]      nodes_ff, nodes_in;
   logic [tst_pkg::IDS_W-1:0]      ids_ff, ids_in;
   logic [tst_pkg::STATUS_W-1:0]   fail_ff, fail_in;
   logic [tst_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [tst_pkg::ID_W-1:0]       res_id_ff, res_id_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tst_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [tst_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;

   tst_pkg::link_wr_type           link_wr;
   logic                           link_rd_en;
   logic [tst_pkg::NODE_AW-1:0]    link_rd_data;
   tst_pkg::sym_wr_type            sym_wr;
   logic                           sym_rd_en;
   logic [tst_pkg::SYM_W-1:0]      sym_rd_data;

   logic [9:0]                     char_ext;
   logic                           bad_char;
   logic [tst_pkg::POS_W-1:0]      pos;
   logic [tst_pkg::LINK_AW-1:0]    slot_calc;
   logic [tst_pkg::STATUS_W-1:0]   fail_now;

   assign char_ext = {2'b00, req_chan.character};
   assign bad_char = (char_ext < 10'(tst_pkg::FIRST_CHAR)) ||
                     (char_ext >= 10'(tst_pkg::CHAR_END));
   assign pos = tst_pkg::POS_W'(req_chan.character - 8'(tst_pkg::FIRST_CHAR));
   assign slot_calc = tst_pkg::LINK_AW'(cur_ff) * tst_pkg::LINK_AW'(tst_pkg::ALPHABET)
                    + tst_pkg::LINK_AW'(pos);

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.symbol_id = rsp_id_ff;

   tst_link_store u_links (
      .clock   (clock),
      .wr      (link_wr),
      .rd_en   (link_rd_en),
      .rd_addr (slot_calc),
      .rd_data (link_rd_data)
   );

   tst_symbol_store u_symbols (
      .clock   (clock),
      .wr      (sym_wr),
      .rd_en   (sym_rd_en),
      .rd_addr (cur_in),
      .rd_data (sym_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      nodes_in      = nodes_ff;
      ids_in        = ids_ff;
      fail_in       = fail_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      link_wr       = '0;
      link_rd_en    = 1'b0;
      sym_wr        = '0;
      sym_rd_en     = 1'b0;
      fail_now      = tst_pkg::ST_OK;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            link_wr.en   = 1'b1;
            link_wr.addr = clr_ff;
            link_wr.data = '0;
            if (clr_ff < tst_pkg::LINK_AW'(tst_pkg::NODE_COUNT)) begin
               sym_wr.en   = 1'b1;
               sym_wr.addr = clr_ff[tst_pkg::NODE_AW-1:0];
               sym_wr.data = tst_pkg::NO_SYMBOL;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == tst_pkg::LINK_AW'(tst_pkg::LINK_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in  = req_chan.command;
               last_in = req_chan.last_char;
               if (fail_ff != tst_pkg::ST_OK) begin
                  // name already failed: only the last character matters
                  res_status_in = fail_ff;
                  res_id_in     = '0;
                  state_in      = req_chan.last_char ? S_DONE : S_IDLE;
               end else if (bad_char) begin
                  fail_in       = tst_pkg::ST_BAD_CHAR;
                  res_status_in = tst_pkg::ST_BAD_CHAR;
                  res_id_in     = '0;
                  state_in      = req_chan.last_char ? S_DONE : S_IDLE;
               end else begin
                  link_rd_en = 1'b1;
                  slot_in    = slot_calc;
                  state_in   = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (link_rd_data != '0) begin
               cur_in = link_rd_data;
            end else if (cmd_ff == tst_pkg::CMD_LOOKUP) begin
               fail_now = tst_pkg::ST_NOT_FOUND;
            end else if (nodes_ff >= (tst_pkg::NODE_AW + 1)'(tst_pkg::NODE_COUNT)) begin
               fail_now = tst_pkg::ST_POOL_FULL;
            end else begin
               // missing branch on insert: take the next free node
               link_wr.en   = 1'b1;
               link_wr.addr = slot_ff;
               link_wr.data = nodes_ff[tst_pkg::NODE_AW-1:0];
               cur_in       = nodes_ff[tst_pkg::NODE_AW-1:0];
               nodes_in     = nodes_ff + 1'b1;
            end
            fail_in = fail_now;
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (fail_now != tst_pkg::ST_OK) begin
               res_status_in = fail_now;
               res_id_in     = '0;
               state_in      = S_DONE;
            end else begin
               sym_rd_en = 1'b1;
               state_in  = S_SYM;
            end
         end
         S_SYM: begin
            res_status_in = tst_pkg::ST_OK;
            res_id_in     = '0;
            if (cmd_ff == tst_pkg::CMD_INSERT) begin
               if (sym_rd_data != tst_pkg::NO_SYMBOL) begin
                  res_status_in = tst_pkg::ST_DEFINED;
               end else if (ids_ff >= tst_pkg::IDS_W'(tst_pkg::ID_COUNT)) begin
                  res_status_in = tst_pkg::ST_IDS_FULL;
               end else begin
                  res_id_in   = tst_pkg::ID_W'(ids_ff);
                  sym_wr.en   = 1'b1;
                  sym_wr.addr = cur_ff;
                  sym_wr.data = tst_pkg::SYM_W'(ids_ff);
                  ids_in      = ids_ff + 1'b1;
               end
            end else begin
               if (sym_rd_data == tst_pkg::NO_SYMBOL) begin
                  res_status_in = tst_pkg::ST_NOT_FOUND;
               end else begin
                  res_id_in = tst_pkg::ID_W'(sym_rd_data);
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = (res_status_ff == tst_pkg::ST_OK) ? res_id_ff : '0;
               cur_in        = '0;
               fail_in       = tst_pkg::ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '0;
         nodes_ff     <= (tst_pkg::NODE_AW + 1)'(1);
         ids_ff       <= '0;
         fail_ff      <= tst_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         nodes_ff     <= nodes_in;
         ids_ff       <= ids_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      last_ff       <= last_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

endmodule

### hdl/tst_link_store.sv
// ----------------------------------------------------------------------------
// tst_link_store
// Child link memory, one entry per (node, branch), registered read.
// ----------------------------------------------------------------------------
module tst_link_store (
   input  logic                          clock,
   input  tst_pkg::link_wr_type          wr,
   input  logic                          rd_en,
   input  logic [tst_pkg::LINK_AW-1:0]   rd_addr,
   output logic [tst_pkg::NODE_AW-1:0]   rd_data
);

   logic [tst_pkg::NODE_AW-1:0] mem [tst_pkg::LINK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hdl/tst_symbol_store.sv
// ----------------------------------------------------------------------------
// tst_symbol_store
// Per-node symbol id memory, registered read.
// ----------------------------------------------------------------------------
module tst_symbol_store (
   input  logic                          clock,
   input  tst_pkg::sym_wr_type           wr,
   input  logic                          rd_en,
   input  logic [tst_pkg::NODE_AW-1:0]   rd_addr,
   output logic [tst_pkg::SYM_W-1:0]     rd_data
);

   logic [tst_pkg::SYM_W-1:0] mem [tst_pkg::NODE_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### dv/trie_symbol_table_top_test.sv
// ----------------------------------------------------------------------------
// trie_symbol_table_top_test
// Self-checking bench for the trie symbol table. Names are streamed one
// character per item; a local trie tracks links, symbol ids and the node
// pool, and each returned status/id is checked in order against it.
// ----------------------------------------------------------------------------
module trie_symbol_table_top_test;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_CHARS = 330;
   localparam int MAX_LEN      = 8;

   typedef struct packed {
      logic [tst_pkg::STATUS_W-1:0] status;
      logic [tst_pkg::ID_W-1:0]     id;
   } name_result_type;

   typedef struct packed {
      logic [3:0]              len;
      logic [MAX_LEN-1:0][7:0] text;
   } name_type;

   logic clock;
   logic reset;

   tst_req_if req_if ();
   tst_rsp_if rsp_if ();

   trie_symbol_table_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // local copy of the trie
   bit [tst_pkg::NODE_AW-1:0] link_mem [tst_pkg::LINK_DEPTH];
   bit [tst_pkg::SYM_W-1:0]   sym_mem  [tst_pkg::NODE_COUNT];
   int                        cur_node;
   int                        nodes_taken;
   int                        ids_taken;
   logic [tst_pkg::STATUS_W-1:0] walk_status;

   name_result_type results_due [$];
   name_type        known_names [$];

   int req_gap_max;
   int rsp_gap_max;
   int rsp_hold_cycles;
   int cycle_count;
   int chars_sent;
   int results_checked;
   int mismatches;
   int status_seen [8];

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results still pending",
                  cycle_count, results_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Walk one character through the local trie; a last character queues
   // the result the name should produce.
   task automatic walk_trie_char(input logic cmd, input logic [tst_pkg::CHAR_W-1:0] ch,
                                 input logic last);
      int                      slot;
      int                      nxt;
      logic [tst_pkg::SYM_W-1:0] sym;
      name_result_type         res;
      if (walk_status == tst_pkg::ST_OK) begin
         if (ch < tst_pkg::FIRST_CHAR || ch >= tst_pkg::CHAR_END) begin
            walk_status = tst_pkg::ST_BAD_CHAR;
         end else begin
            slot = cur_node * tst_pkg::ALPHABET + (ch - tst_pkg::FIRST_CHAR);
            nxt  = link_mem[slot];
            if (nxt == 0) begin
               if (cmd == tst_pkg::CMD_LOOKUP) begin
                  walk_status = tst_pkg::ST_NOT_FOUND;
               end else if (nodes_taken >= tst_pkg::NODE_COUNT) begin
                  walk_status = tst_pkg::ST_POOL_FULL;
               end else begin
                  nxt = nodes_taken;
                  nodes_taken++;
                  link_mem[slot] = tst_pkg::NODE_AW'(nxt);
               end
            end
            if (walk_status == tst_pkg::ST_OK) cur_node = nxt;
         end
      end
      if (last) begin
         res.status = walk_status;
         res.id     = '0;
         if (walk_status == tst_pkg::ST_OK) begin
            sym = sym_mem[cur_node];
            if (cmd == tst_pkg::CMD_INSERT) begin
               if (sym != tst_pkg::NO_SYMBOL) begin
                  res.status = tst_pkg::ST_DEFINED;
               end else if (ids_taken >= tst_pkg::ID_COUNT) begin
                  res.status = tst_pkg::ST_IDS_FULL;
               end else begin
                  res.id = ids_taken[tst_pkg::ID_W-1:0];
                  sym_mem[cur_node] = ids_taken[tst_pkg::SYM_W-1:0];
                  ids_taken++;
               end
            end else if (sym == tst_pkg::NO_SYMBOL) begin
               res.status = tst_pkg::ST_NOT_FOUND;
            end else begin
               res.id = sym[tst_pkg::ID_W-1:0];
            end
         end
         results_due.push_back(res);
         cur_node    = 0;
         walk_status = tst_pkg::ST_OK;
      end
   endtask

   // Entered and left at a falling edge; valid stays up for back-to-back items.
   task automatic send_char(input logic cmd, input logic [tst_pkg::CHAR_W-1:0] ch,
                            input logic last);
      int gap;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.command   <= cmd;
      req_if.character <= ch;
      req_if.last_char <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      walk_trie_char(cmd, ch, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_name(input logic cmd, input name_type nm);
      for (int i = 0; i < nm.len; i++) send_char(cmd, nm.text[i], i == nm.len - 1);
   endtask

   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic name_type make_name(input int len, input bit narrow);
      name_type nm;
      nm = '0;
      nm.len = len[3:0];
      for (int i = 0; i < len; i++)
         nm.text[i] = narrow ? 8'(int'("a") + $urandom_range(0, 3))
                             : 8'($urandom_range(tst_pkg::FIRST_CHAR,
                                                 tst_pkg::CHAR_END - 1));
      return nm;
   endfunction

   function automatic logic [7:0] bad_char();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, tst_pkg::FIRST_CHAR - 1))
                                  : 8'($urandom_range(tst_pkg::CHAR_END, 255));
   endfunction

   function automatic name_type name_of(input string s);
      name_type nm;
      nm = '0;
      nm.len = 4'(s.len());
      for (int i = 0; i < s.len(); i++) nm.text[i] = s[i];
      return nm;
   endfunction

   task automatic set_idle_mode(input int mode);
      req_gap_max = (mode == 0 || mode == 2) ? 13 : 0;
      rsp_gap_max = (mode == 0 || mode == 3) ? 13 : 0;
   endtask

   // Result side: random ready gaps, or one long hold when asked.
   initial begin : result_sink
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_if.valid && rsp_if.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : check_results
      name_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_checked++;
         status_seen[rsp_if.status]++;
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR @%0d: unexpected result status %0d id %0d",
                        cycle_count, rsp_if.status, rsp_if.symbol_id);
         end else begin
            want = results_due.pop_front();
            if (rsp_if.status !== want.status || rsp_if.symbol_id !== want.id) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR @%0d: status exp %0d got %0d, id exp %0d got %0d",
                           cycle_count, want.status, rsp_if.status, want.id,
                           rsp_if.symbol_id);
            end
         end
      end
   end

   // Edges of the character range, the not-found, defined and bad-char statuses,
   // failure latching and a command switch inside a name.
   task automatic test_directed();
      set_idle_mode(0);
      send_name(tst_pkg::CMD_LOOKUP, name_of("A"));             // empty table
      send_char(tst_pkg::CMD_INSERT, 8'd32, 1'b1);
      send_char(tst_pkg::CMD_INSERT, 8'd127, 1'b1);
      send_char(tst_pkg::CMD_INSERT, 8'd32, 1'b1);              // already defined
      send_char(tst_pkg::CMD_LOOKUP, 8'd127, 1'b1);
      send_char(tst_pkg::CMD_INSERT, 8'd32, 1'b0);
      send_char(tst_pkg::CMD_INSERT, 8'd127, 1'b1);
      send_char(tst_pkg::CMD_LOOKUP, 8'd32, 1'b0);
      send_char(tst_pkg::CMD_LOOKUP, 8'd127, 1'b1);
      send_name(tst_pkg::CMD_INSERT, name_of("xyz"));
      send_name(tst_pkg::CMD_LOOKUP, name_of("xy"));            // path exists, no symbol
      send_char(tst_pkg::CMD_INSERT, 8'd0, 1'b1);
      send_char(tst_pkg::CMD_LOOKUP, 8'd255, 1'b1);
      send_char(tst_pkg::CMD_INSERT, 8'd31, 1'b0);              // bad first char, rest ignored
      send_char(tst_pkg::CMD_INSERT, 8'd97, 1'b0);
      send_char(tst_pkg::CMD_INSERT, 8'd128, 1'b1);
      send_name(tst_pkg::CMD_LOOKUP, name_of("xqy"));           // missing branch, then more
      send_char(tst_pkg::CMD_LOOKUP, 8'd120, 1'b0);             // command flips mid-name
      send_char(tst_pkg::CMD_INSERT, 8'd119, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_names();
      int       sent;
      int       pick;
      int       bad_pos;
      name_type nm;
      sent = 0;
      while (sent < RANDOM_CHARS) begin
         if (sent % 60 == 0) set_idle_mode($urandom_range(0, 3));
         pick = $urandom_range(0, 99);
         if (pick < 35 || known_names.size() == 0) begin
            nm = make_name($urandom_range(1, 5), $urandom_range(0, 2) != 0);
            send_name(tst_pkg::CMD_INSERT, nm);
            known_names.push_back(nm);
         end else if (pick < 45) begin
            nm = known_names[$urandom_range(0, known_names.size() - 1)];
            send_name(tst_pkg::CMD_INSERT, nm);
         end else if (pick < 65) begin
            nm = known_names[$urandom_range(0, known_names.size() - 1)];
            if (nm.len > 1 && $urandom_range(0, 3) == 0)
               nm.len = 4'($urandom_range(1, nm.len - 1));
            send_name(tst_pkg::CMD_LOOKUP, nm);
         end else if (pick < 85) begin
            nm = make_name($urandom_range(1, 4), 1'($urandom_range(0, 1)));
            send_name(tst_pkg::CMD_LOOKUP, nm);
         end else begin
            // broken names: a bad character somewhere or a command that wanders
            nm = make_name($urandom_range(1, 5), 1'($urandom_range(0, 1)));
            bad_pos = $urandom_range(0, 2) == 0 ? MAX_LEN : $urandom_range(0, nm.len - 1);
            for (int i = 0; i < nm.len; i++)
               send_char(1'($urandom_range(0, 1)),
                         (i == bad_pos) ? bad_char() : nm.text[i], i == nm.len - 1);
         end
         sent += nm.len;
      end
      wait_for_drain();
   endtask

   // Results are held back while names keep coming, so the input stalls.
   task automatic test_result_backpressure();
      set_idle_mode(1);
      rsp_hold_cycles = 400;
      for (int i = 0; i < 30; i++)
         send_name(1'($urandom_range(0, 1)), make_name($urandom_range(1, 2), 1'b1));
      wait_for_drain();
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.command   = tst_pkg::CMD_LOOKUP;
      req_if.character = '0;
      req_if.last_char = 1'b0;
      for (int i = 0; i < tst_pkg::NODE_COUNT; i++) sym_mem[i] = tst_pkg::NO_SYMBOL;
      cur_node    = 0;
      nodes_taken = 1;
      ids_taken   = 0;
      walk_status = tst_pkg::ST_OK;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_names();
      test_result_backpressure();

      if (results_due.size() != 0) begin
         mismatches += results_due.size();
         $display("ERROR: %0d results never arrived", results_due.size());
      end
      if (mismatches > 10) $display("%0d mismatches in total", mismatches);
      $display("Run: %0d characters sent, %0d results checked, %0d of %0d nodes, %0d ids",
               chars_sent, results_checked, nodes_taken, tst_pkg::NODE_COUNT, ids_taken);
      $display("Statuses: ok %0d, not found %0d, defined %0d, pool full %0d, bad char %0d",
               status_seen[tst_pkg::ST_OK], status_seen[tst_pkg::ST_NOT_FOUND],
               status_seen[tst_pkg::ST_DEFINED], status_seen[tst_pkg::ST_POOL_FULL],
               status_seen[tst_pkg::ST_BAD_CHAR]);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
